FILE: rtl/acbd_pkg.sv
// Shared types, constants and saturating helpers for the ADMM duty update block.
package acbd_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int DUTY_MAX_DEF  = 100;
  localparam int LANES         = 3;
  localparam int COST_W        = 36;
  localparam int BOUND_W       = 35;

  localparam logic signed [31:0] QMAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] QMIN = 32'sh80000000;

  localparam logic [2:0] CASE_UNC  = 3'd0;
  localparam logic [2:0] CASE_NONE = 3'd6;

  localparam logic [2:0] CAND_LAST = 3'd4;

  typedef enum logic [2:0] {
    REG_GAIN_ZERO,
    REG_GAIN_ONE,
    REG_GAIN_TWO,
    REG_BACKGROUND,
    REG_REFERENCE,
    REG_OWN_INDEX,
    REG_PENALTY,
    REG_SLACK
  } cfg_reg_t;

  typedef enum logic {
    OP_MUL,
    OP_DIV
  } lane_op_t;

  typedef struct packed {
    logic clear;
    logic init;
    logic lin;
    logic quad;
    logic decide;
  } merge_ctrl_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ZMUL,
    ST_UDIV,
    ST_UFEAS,
    ST_GMUL,
    ST_NMUL,
    ST_GPDIV,
    ST_T4MUL,
    ST_KNDIV,
    ST_GMDIV,
    ST_GMPDIV,
    ST_CORRMUL,
    ST_C1MUL,
    ST_C4MUL,
    ST_C5MUL,
    ST_CFEAS,
    ST_CEMUL,
    ST_CEEMUL,
    ST_CPMUL,
    ST_CDEC,
    ST_CNEXT,
    ST_FIN
  } state_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'(QMAX)) begin
      r = QMAX;
    end else if (v < 64'(QMIN)) begin
      r = QMIN;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] qadd(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] s;
    s = 64'(a) + 64'(b);
    return sat32(s);
  endfunction

  function automatic logic signed [31:0] qsub(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] s;
    s = 64'(a) - 64'(b);
    return sat32(s);
  endfunction

endpackage

FILE: rtl/acbd_in_if.sv
// Input item channel: dual vector and averaged duty vector.
interface acbd_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] dual_zero;
  logic signed [31:0] dual_one;
  logic signed [31:0] dual_two;
  logic signed [31:0] mean_zero;
  logic signed [31:0] mean_one;
  logic signed [31:0] mean_two;

  modport source (
    output valid, dual_zero, dual_one, dual_two, mean_zero, mean_one, mean_two,
    input  ready
  );
  modport sink (
    input  valid, dual_zero, dual_one, dual_two, mean_zero, mean_one, mean_two,
    output ready
  );
endinterface

FILE: rtl/acbd_out_if.sv
// Result item channel: chosen duty vector and case index.
interface acbd_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] duty_zero;
  logic signed [31:0] duty_one;
  logic signed [31:0] duty_two;
  logic [2:0]         chosen_case;

  modport source (
    output valid, duty_zero, duty_one, duty_two, chosen_case,
    input  ready
  );
  modport sink (
    input  valid, duty_zero, duty_one, duty_two, chosen_case,
    output ready
  );
endinterface

FILE: rtl/acbd_lane.sv
// One arithmetic lane: saturating fixed-point multiply and bit-serial divide.
module acbd_lane import acbd_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  lane_op_t           op,
  input  logic signed [31:0] op_a,
  input  logic signed [31:0] op_b,
  output logic               done,
  output logic signed [31:0] result
);

  localparam int DW = 32 + FRAC_BITS;
  localparam int CW = $clog2(DW + 1);

  logic signed [63:0] prod_r;
  logic [DW-1:0]      dd_r;
  logic [31:0]        rem_r;
  logic [31:0]        dvs_r;
  logic [CW-1:0]      cnt_r;
  logic               busy_r;
  logic               done_r;
  lane_op_t           op_r;
  logic               neg_r;
  logic               zb_r;
  logic               az_r;
  logic               an_r;

  logic [31:0]        mag_a;
  logic [31:0]        mag_b;
  logic [32:0]        cat;
  logic [32:0]        diff;
  logic               qbit;
  logic signed [63:0] shifted;
  logic               q_ge;
  logic               q_gt;

  assign mag_a = op_a[31] ? (~op_a + 32'd1) : op_a;
  assign mag_b = op_b[31] ? (~op_b + 32'd1) : op_b;
  assign cat   = {rem_r, dd_r[DW-1]};
  assign diff  = cat - {1'b0, dvs_r};
  assign qbit  = ~diff[32];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        if (op == OP_MUL) begin
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
          cnt_r  <= CW'(DW);
        end
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      op_r   <= op;
      prod_r <= op_a * op_b;
      dd_r   <= {mag_a, {FRAC_BITS{1'b0}}};
      rem_r  <= '0;
      dvs_r  <= mag_b;
      neg_r  <= op_a[31] ^ op_b[31];
      zb_r   <= (op_b == '0);
      az_r   <= (op_a == '0);
      an_r   <= op_a[31];
    end else if (busy_r) begin
      rem_r <= qbit ? diff[31:0] : cat[31:0];
      dd_r  <= {dd_r[DW-2:0], qbit};
    end
  end

  assign shifted = prod_r >>> FRAC_BITS;
  assign q_ge    = |dd_r[DW-1:31];
  assign q_gt    = (|dd_r[DW-1:32]) || (dd_r[31] && (|dd_r[30:0]));

  always_comb begin
    if (op_r == OP_MUL) begin
      result = sat32(shifted);
    end else if (zb_r) begin
      result = az_r ? '0 : (an_r ? QMIN : QMAX);
    end else if (!neg_r) begin
      result = q_ge ? QMAX : $signed(dd_r[31:0]);
    end else begin
      result = q_gt ? QMIN : $signed(~dd_r[31:0] + 32'd1);
    end
  end

  assign done = done_r;

endmodule

FILE: rtl/acbd_merge.sv
// Merge stage: lane sum, feasibility test, cost accumulation and best pick.
module acbd_merge import acbd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  merge_ctrl_t        ctrl,
  input  logic signed [31:0] prod [LANES],
  input  logic signed [31:0] d_own,
  input  logic signed [31:0] dmax,
  input  logic signed [31:0] bg_level,
  input  logic signed [31:0] ref_level,
  input  logic [30:0]        slack,
  output logic signed [31:0] sum3,
  output logic               feas,
  output logic               take
);

  logic signed [33:0]        sum_w;
  logic signed [32:0]        slack_s;
  logic signed [32:0]        own_v;
  logic signed [BOUND_W-1:0] bound;
  logic                      own_ok;
  logic signed [COST_W-1:0]  acc_r;
  logic signed [COST_W-1:0]  best_r;
  logic                      have_r;

  assign sum_w   = 34'(prod[0]) + 34'(prod[1]) + 34'(prod[2]);
  assign sum3    = sat32(64'(sum_w));
  assign slack_s = $signed({2'b00, slack});
  assign own_v   = 33'(d_own);
  assign own_ok  = !(own_v < -slack_s) && !(own_v > (33'(dmax) + slack_s));
  assign bound   = BOUND_W'(ref_level) - BOUND_W'(bg_level) - BOUND_W'(slack_s);
  assign feas    = own_ok && !(BOUND_W'(sum3) < bound);
  assign take    = ctrl.decide && (!have_r || (acc_r < best_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
    end else if (ctrl.clear) begin
      have_r <= 1'b0;
    end else if (take) begin
      have_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.init) begin
      acc_r <= COST_W'(d_own);
    end else if (ctrl.lin) begin
      acc_r <= acc_r + COST_W'(sum_w);
    end else if (ctrl.quad) begin
      acc_r <= acc_r + COST_W'(prod[0] >>> 1);
    end
    if (take) begin
      best_r <= acc_r;
    end
  end

endmodule

FILE: rtl/admm_box_constrained_duty_update_core.sv
// Top level: local ADMM primal duty update with box and illuminance bounds.
//
// Usage: in_ch carries one item of dual and averaged duty vectors; out_ch
// returns one item with the chosen duty vector and case index. Items move
// on valid and ready both high. cfg_we writes register cfg_index with
// cfg_data; write only while no item is in flight.
// Three lanes, one per vector element, each hold a multiplier and a
// one-bit-per-cycle divider; a merge stage sums lane products, checks
// feasibility and keeps the cheapest candidate.
// A feasible unconstrained point costs two multiplies and one divide;
// otherwise four more divide steps and further multiply and compare
// work follow. One item is worked at a time; the block is ready for the
// next item as soon as the result is registered.
// The output register frees the datapath: a new item is taken while a
// result waits, and the next result holds until the receiver takes it.
// Reset: registers take their defaults, kept duty clears, channels go idle.
// Writing reference_level clears the kept duty.
module admm_box_constrained_duty_update_core import acbd_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int DUTY_MAX  = DUTY_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  acbd_in_if.sink     in_ch,
  acbd_out_if.source  out_ch,
  input  logic        cfg_we,
  input  cfg_reg_t    cfg_index,
  input  logic [31:0] cfg_data
);

  localparam longint DMAX_L = longint'(DUTY_MAX) << FRAC_BITS;
  localparam logic signed [31:0] DMAX_Q = (DMAX_L > 64'sd2147483647) ? QMAX : 32'(DMAX_L);
  localparam logic signed [31:0] ONE_Q  = 32'(longint'(1) << FRAC_BITS);

  logic [30:0]        gain_r [LANES];
  logic signed [31:0] bg_r;
  logic signed [31:0] ref_r;
  logic [1:0]         own_r;
  logic [30:0]        pen_r;
  logic [30:0]        slack_r;
  logic signed [31:0] kept_r [LANES];

  logic signed [31:0] y_r    [LANES];
  logic signed [31:0] avg_r  [LANES];
  logic signed [31:0] z_r    [LANES];
  logic signed [31:0] u_r    [LANES];
  logic signed [31:0] kn_r   [LANES];
  logic signed [31:0] gm_r   [LANES];
  logic signed [31:0] gmp_r  [LANES];
  logic signed [31:0] corr_r [LANES];
  logic signed [31:0] c1_r   [LANES];
  logic signed [31:0] c4_r   [LANES];
  logic signed [31:0] c5_r   [LANES];
  logic signed [31:0] best_r [LANES];
  logic signed [31:0] g_r;
  logic signed [31:0] n_r;
  logic signed [31:0] m_r;
  logic signed [31:0] w_r;
  logic signed [31:0] pzid_r;
  logic signed [31:0] diff_r;
  logic signed [31:0] t0_r;
  logic signed [31:0] t4_r;
  logic signed [31:0] ee_r;
  logic [2:0]         case_r;
  logic [2:0]         cj_r;

  state_t             state_r;
  state_t             state_nxt;
  logic               started_r;
  logic               started_nxt;

  logic               out_valid_r;
  logic signed [31:0] out_duty_r [LANES];
  logic [2:0]         out_case_r;

  logic               accept;
  logic               out_free;
  logic [1:0]         own_id;
  logic signed [31:0] gain_s [LANES];
  logic signed [31:0] pen_s;
  logic signed [31:0] cur   [LANES];
  logic signed [31:0] err   [LANES];
  logic signed [31:0] fin_vec [LANES];
  logic               found;

  logic               lane_start;
  lane_op_t           lane_op;
  logic signed [31:0] opa [LANES];
  logic signed [31:0] opb [LANES];
  logic [LANES-1:0]   lane_done;
  logic signed [31:0] lane_res [LANES];
  logic               done;

  merge_ctrl_t        mctl;
  logic signed [31:0] sum3;
  logic               feas;
  logic               take;

  assign accept   = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);
  assign out_free = !out_valid_r || out_ch.ready;
  assign own_id   = (own_r == 2'd3) ? 2'd2 : own_r;
  assign pen_s    = $signed({1'b0, pen_r});
  assign done     = lane_done[0];
  assign found    = (case_r != CASE_NONE);

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      gain_s[i] = $signed({1'b0, gain_r[i]});
    end
  end

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      if (state_r == ST_UFEAS) begin
        cur[i] = u_r[i];
      end else begin
        unique case (cj_r)
          3'd0:    cur[i] = c1_r[i];
          3'd1:    cur[i] = (2'(i) == own_id) ? '0 : u_r[i];
          3'd2:    cur[i] = (2'(i) == own_id) ? DMAX_Q : u_r[i];
          3'd3:    cur[i] = c4_r[i];
          default: cur[i] = c5_r[i];
        endcase
      end
      err[i]     = qsub(cur[i], avg_r[i]);
      fin_vec[i] = found ? best_r[i] : kept_r[i];
    end
  end

  for (genvar gi = 0; gi < LANES; gi++) begin : g_lane
    acbd_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .start  (lane_start),
      .op     (lane_op),
      .op_a   (opa[gi]),
      .op_b   (opb[gi]),
      .done   (lane_done[gi]),
      .result (lane_res[gi])
    );
  end

  acbd_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (mctl),
    .prod      (lane_res),
    .d_own     (cur[own_id]),
    .dmax      (DMAX_Q),
    .bg_level  (bg_r),
    .ref_level (ref_r),
    .slack     (slack_r),
    .sum3      (sum3),
    .feas      (feas),
    .take      (take)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:    if (accept) state_nxt = ST_ZMUL;
      ST_ZMUL:    if (done) state_nxt = ST_UDIV;
      ST_UDIV:    if (done) state_nxt = ST_UFEAS;
      ST_UFEAS:   if (done) state_nxt = feas ? ST_FIN : ST_GMUL;
      ST_GMUL:    if (done) state_nxt = ST_NMUL;
      ST_NMUL:    if (done) state_nxt = ST_GPDIV;
      ST_GPDIV:   if (done) state_nxt = ST_T4MUL;
      ST_T4MUL:   if (done) state_nxt = ST_KNDIV;
      ST_KNDIV:   if (done) state_nxt = ST_GMDIV;
      ST_GMDIV:   if (done) state_nxt = ST_GMPDIV;
      ST_GMPDIV:  if (done) state_nxt = ST_CORRMUL;
      ST_CORRMUL: if (done) state_nxt = ST_C1MUL;
      ST_C1MUL:   if (done) state_nxt = ST_C4MUL;
      ST_C4MUL:   if (done) state_nxt = ST_C5MUL;
      ST_C5MUL:   if (done) state_nxt = ST_CFEAS;
      ST_CFEAS:   if (done) state_nxt = feas ? ST_CEMUL : ST_CNEXT;
      ST_CEMUL:   if (done) state_nxt = ST_CEEMUL;
      ST_CEEMUL:  if (done) state_nxt = ST_CPMUL;
      ST_CPMUL:   if (done) state_nxt = ST_CDEC;
      ST_CDEC:    state_nxt = ST_CNEXT;
      ST_CNEXT:   state_nxt = (cj_r == CAND_LAST) ? ST_FIN : ST_CFEAS;
      ST_FIN:     if (out_free) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // lane and merge controls
  always_comb begin
    lane_start = 1'b0;
    lane_op    = OP_MUL;
    mctl       = '0;
    for (int i = 0; i < LANES; i++) begin
      opa[i] = '0;
      opb[i] = '0;
    end
    unique case (state_r)
      ST_IDLE, ST_CDEC, ST_CNEXT, ST_FIN: lane_start = 1'b0;
      default:                            lane_start = !started_r;
    endcase
    unique case (state_r)
      ST_IDLE: mctl.clear = accept;
      ST_ZMUL: begin
        for (int i = 0; i < LANES; i++) begin
          opa[i] = pen_s;
          opb[i] = avg_r[i];
        end
      end
      ST_UDIV: begin
        lane_op = OP_DIV;
        for (int i = 0; i < LANES; i++) begin
          opa[i] = z_r[i];
          opb[i] = pen_s;
        end
      end
      ST_UFEAS, ST_CFEAS: begin
        for (int i = 0; i < LANES; i++) begin
          opa[i] = cur[i];
          opb[i] = gain_s[i];
        end
        mctl.init = (state_r == ST_CFEAS) && done && feas;
      end
      ST_GMUL: begin
        for (int i = 0; i < LANES; i++) begin
          opa[i] = z_r[i];
          opb[i] = gain_s[i];
        end
      end
      ST_NMUL: begin
        for (int i = 0; i < LANES; i++) begin
          opa[i] = gain_s[i];
          opb[i] = gain_s[i];
        end
      end
      ST_GPDIV: begin
        lane_op = OP_DIV;
        for (int i = 0; i < LANES; i++) begin
          opa[i] = g_r;
          opb[i] = pen_s;
        end
      end
      ST_T4MUL: begin
        for (int i = 0; i < LANES; i++) begin
          opa[i] = DMAX_Q;
          opb[i] = gain_s[own_id];
        end
      end
      ST_KNDIV: begin
        lane_op = OP_DIV;
        for (int i = 0; i < LANES; i++) begin
          opa[i] = gain_s[i];
          opb[i] = n_r;
        end
      end
      ST_GMDIV: begin
        lane_op = OP_DIV;
        for (int i = 0; i < LANES; i++) begin
          opa[i] = gain_s[i];
          opb[i] = m_r;
        end
      end
      ST_GMPDIV: begin
        lane_op = OP_DIV;
        for (int i = 0; i < LANES; i++) begin
          opa[i] = gm_r[i];
          opb[i] = pen_s;
        end
      end
      ST_CORRMUL: begin
        for (int i = 0; i < LANES; i++) begin
          opa[i] = gmp_r[i];
          opb[i] = w_r;
        end
      end
      ST_C1MUL: begin
        for (int i = 0; i < LANES; i++) begin
          opa[i] = kn_r[i];
          opb[i] = t0_r;
        end
      end
      ST_C4MUL: begin
        for (int i = 0; i < LANES; i++) begin
          opa[i] = gm_r[i];
          opb[i] = diff_r;
        end
      end
      ST_C5MUL: begin
        for (int i = 0; i < LANES; i++) begin
          opa[i] = gm_r[i];
          opb[i] = t4_r;
        end
      end
      ST_CEMUL: begin
        for (int i = 0; i < LANES; i++) begin
          opa[i] = y_r[i];
          opb[i] = err[i];
        end
        mctl.lin = done;
      end
      ST_CEEMUL: begin
        for (int i = 0; i < LANES; i++) begin
          opa[i] = err[i];
          opb[i] = err[i];
        end
      end
      ST_CPMUL: begin
        for (int i = 0; i < LANES; i++) begin
          opa[i] = pen_s;
          opb[i] = ee_r;
        end
        mctl.quad = done;
      end
      ST_CDEC:  mctl.decide = 1'b1;
      ST_CNEXT: mctl = '0;
      ST_FIN:   mctl = '0;
      default:  mctl = '0;
    endcase
  end

  always_comb begin
    started_nxt = started_r;
    if (done) begin
      started_nxt = 1'b0;
    end else if (lane_start) begin
      started_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
      gain_r[0]   <= 31'd65536;
      gain_r[1]   <= 31'd65536;
      gain_r[2]   <= 31'd65536;
      bg_r        <= '0;
      ref_r       <= '0;
      own_r       <= '0;
      pen_r       <= 31'd45875;
      slack_r     <= 31'd66;
      for (int i = 0; i < LANES; i++) begin
        kept_r[i] <= '0;
      end
    end else begin
      state_r   <= state_nxt;
      started_r <= started_nxt;
      if (state_r == ST_FIN && out_free) begin
        out_valid_r <= 1'b1;
        for (int i = 0; i < LANES; i++) begin
          kept_r[i] <= fin_vec[i];
        end
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_GAIN_ZERO:  gain_r[0] <= cfg_data[30:0];
          REG_GAIN_ONE:   gain_r[1] <= cfg_data[30:0];
          REG_GAIN_TWO:   gain_r[2] <= cfg_data[30:0];
          REG_BACKGROUND: bg_r      <= $signed(cfg_data);
          REG_REFERENCE: begin
            ref_r <= $signed(cfg_data);
            for (int i = 0; i < LANES; i++) begin
              kept_r[i] <= '0;
            end
          end
          REG_OWN_INDEX:  own_r     <= cfg_data[1:0];
          REG_PENALTY:    pen_r     <= cfg_data[30:0];
          REG_SLACK:      slack_r   <= cfg_data[30:0];
          default:        own_r     <= own_r;
        endcase
      end
    end
  end

  // datapath captures
  always_ff @(posedge clk) begin
    if (accept) begin
      y_r[0]   <= in_ch.dual_zero;
      y_r[1]   <= in_ch.dual_one;
      y_r[2]   <= in_ch.dual_two;
      avg_r[0] <= in_ch.mean_zero;
      avg_r[1] <= in_ch.mean_one;
      avg_r[2] <= in_ch.mean_two;
      case_r   <= CASE_NONE;
    end
    if (done) begin
      priority case (state_r)
        ST_ZMUL: begin
          for (int i = 0; i < LANES; i++) begin
            z_r[i] <= qsub(qsub(lane_res[i], y_r[i]), (2'(i) == own_id) ? ONE_Q : '0);
          end
        end
        ST_UDIV: begin
          for (int i = 0; i < LANES; i++) begin
            u_r[i] <= lane_res[i];
          end
        end
        ST_UFEAS: begin
          if (feas) begin
            case_r <= CASE_UNC;
            for (int i = 0; i < LANES; i++) begin
              best_r[i] <= u_r[i];
            end
          end
        end
        ST_GMUL: begin
          g_r    <= sum3;
          pzid_r <= lane_res[own_id];
        end
        ST_NMUL: begin
          n_r    <= sum3;
          m_r    <= qsub(sum3, lane_res[own_id]);
          w_r    <= qsub(pzid_r, g_r);
          diff_r <= qsub(bg_r, ref_r);
        end
        ST_GPDIV: t0_r <= qadd(diff_r, lane_res[0]);
        ST_T4MUL: t4_r <= qadd(diff_r, lane_res[0]);
        ST_KNDIV: begin
          for (int i = 0; i < LANES; i++) begin
            kn_r[i] <= lane_res[i];
          end
        end
        ST_GMDIV: begin
          for (int i = 0; i < LANES; i++) begin
            gm_r[i] <= lane_res[i];
          end
        end
        ST_GMPDIV: begin
          for (int i = 0; i < LANES; i++) begin
            gmp_r[i] <= lane_res[i];
          end
        end
        ST_CORRMUL: begin
          for (int i = 0; i < LANES; i++) begin
            corr_r[i] <= lane_res[i];
          end
        end
        ST_C1MUL: begin
          for (int i = 0; i < LANES; i++) begin
            c1_r[i] <= qsub(u_r[i], lane_res[i]);
          end
        end
        ST_C4MUL: begin
          for (int i = 0; i < LANES; i++) begin
            c4_r[i] <= (2'(i) == own_id) ? '0 :
                       qadd(qsub(u_r[i], lane_res[i]), corr_r[i]);
          end
        end
        ST_C5MUL: begin
          cj_r <= '0;
          for (int i = 0; i < LANES; i++) begin
            c5_r[i] <= (2'(i) == own_id) ? DMAX_Q :
                       qadd(qsub(u_r[i], lane_res[i]), corr_r[i]);
          end
        end
        ST_CEEMUL: ee_r <= sum3;
        default:   ee_r <= ee_r;
      endcase
    end
    if (take) begin
      case_r <= cj_r + 3'd1;
      for (int i = 0; i < LANES; i++) begin
        best_r[i] <= cur[i];
      end
    end
    if (state_r == ST_CNEXT) begin
      cj_r <= cj_r + 3'd1;
    end
    if (state_r == ST_FIN && out_free) begin
      out_case_r <= found ? case_r : CASE_NONE;
      for (int i = 0; i < LANES; i++) begin
        out_duty_r[i] <= fin_vec[i];
      end
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.duty_zero   = out_duty_r[0];
  assign out_ch.duty_one    = out_duty_r[1];
  assign out_ch.duty_two    = out_duty_r[2];
  assign out_ch.chosen_case = out_case_r;

  a_lanes_in_step: assert property (@(posedge clk) disable iff (!rst_n)
    (lane_done[0] == lane_done[1]) && (lane_done[1] == lane_done[2]))
    else $error("lanes finished out of step");

  a_done_pending: assert property (@(posedge clk) disable iff (!rst_n)
    lane_done[0] |-> started_r)
    else $error("lane finished without a pending operation");

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FIN))
    else $error("result raised outside the finish step");

  a_case_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_case_r <= CASE_NONE))
    else $error("chosen case out of range");

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the ADMM box-constrained duty update core.
`timescale 1ns / 100ps

module testbench;
  import acbd_pkg::*;

  localparam longint LIM_HI = 64'sd2147483647;
  localparam longint LIM_LO = -64'sd2147483648;
  localparam int     FB = 16;
  localparam int     DMAX = 100;
  localparam int     PHASES = 14;
  localparam int     PER_PHASE = 100;
  localparam int     TIMEOUT = 4000000;
  localparam int     DRAIN = 400;

  typedef struct {
    logic signed [31:0] duty [3];
    logic [2:0]         pick;
  } duty_res_t;

  typedef struct {
    logic signed [31:0] f [6];
    bit                 typed;
    duty_res_t          res;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  cfg_reg_t cfg_index;
  logic [31:0] cfg_data;

  acbd_in_if  in_ch ();
  acbd_out_if out_ch ();

  admm_box_constrained_duty_update_core i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  longint gain_m [3];
  longint bg_m, ref_m, rho_m, slack_m;
  int unsigned own_m;
  longint kept_m [3];

  duty_res_t duty_q [$];
  int errors = 0;
  int n_out = 0;
  int case_hits [7];
  bit quiet = 0;
  int cycles = 0;
  int stall_left = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic longint sat(longint v);
    if (v > LIM_HI) return LIM_HI;
    if (v < LIM_LO) return LIM_LO;
    return v;
  endfunction

  function automatic longint qm(longint a, longint b);
    return sat((a * b) >>> FB);
  endfunction

  function automatic longint qd(longint a, longint b);
    if (b == 0) return a == 0 ? 0 : (a > 0 ? LIM_HI : LIM_LO);
    return sat((a * (64'sd1 <<< FB)) / b);
  endfunction

  function automatic longint dot(longint a [3], longint b [3]);
    return sat(qm(a[0], b[0]) + qm(a[1], b[1]) + qm(a[2], b[2]));
  endfunction

  function automatic int unsigned own_sel();
    return own_m > 2 ? 2 : own_m;
  endfunction

  function automatic bit fits(longint d [3]);
    longint v;
    v = d[own_sel()];
    if (v < -slack_m) return 0;
    if (v > sat(longint'(DMAX) <<< FB) + slack_m) return 0;
    if (dot(d, gain_m) < ref_m - bg_m - slack_m) return 0;
    return 1;
  endfunction

  function automatic longint duty_cost(longint d [3], longint y [3], longint a [3]);
    longint e [3];
    longint c;
    c = d[own_sel()];
    for (int i = 0; i < 3; i++) begin
      e[i] = sat(d[i] - a[i]);
      c += qm(y[i], e[i]);
    end
    c += qm(rho_m, dot(e, e)) / 2;
    return c;
  endfunction

  function automatic duty_res_t predict_duty(logic signed [31:0] f [6]);
    longint y [3], a [3], z [3], u [3], best [3], cand [5][3];
    longint g, n, m, w, diff, t0, t4, bc, c, gm, corr, dm, one;
    int unsigned id;
    logic [2:0] pick;
    duty_res_t r;
    id = own_sel();
    one = 64'sd1 <<< FB;
    dm = sat(longint'(DMAX) <<< FB);
    bc = 0;
    pick = CASE_NONE;
    for (int i = 0; i < 3; i++) begin
      y[i] = f[i];
      a[i] = f[3 + i];
      z[i] = sat(sat(qm(rho_m, a[i]) - y[i]) - (i == id ? one : 0));
      u[i] = qd(z[i], rho_m);
    end
    if (fits(u)) begin
      best = u;
      pick = CASE_UNC;
    end else begin
      g = dot(z, gain_m);
      n = dot(gain_m, gain_m);
      m = sat(n - qm(gain_m[id], gain_m[id]));
      w = sat(qm(gain_m[id], z[id]) - g);
      diff = sat(bg_m - ref_m);
      t0 = sat(diff + qd(g, rho_m));
      t4 = sat(diff + qm(dm, gain_m[id]));
      for (int i = 0; i < 3; i++) begin
        gm = qd(gain_m[i], m);
        corr = qm(qd(gm, rho_m), w);
        cand[0][i] = sat(u[i] - qm(qd(gain_m[i], n), t0));
        cand[1][i] = u[i];
        cand[2][i] = u[i];
        cand[3][i] = sat(sat(u[i] - qm(gm, diff)) + corr);
        cand[4][i] = sat(sat(u[i] - qm(gm, t4)) + corr);
      end
      cand[1][id] = 0;
      cand[2][id] = dm;
      cand[3][id] = 0;
      cand[4][id] = dm;
      for (int j = 0; j < 5; j++) begin
        if (fits(cand[j])) begin
          c = duty_cost(cand[j], y, a);
          if (pick == CASE_NONE || c < bc) begin
            bc = c;
            best = cand[j];
            pick = 3'(j + 1);
          end
        end
      end
    end
    if (pick == CASE_NONE) best = kept_m;
    else kept_m = best;
    for (int i = 0; i < 3; i++) r.duty[i] = best[i][31:0];
    r.pick = pick;
    return r;
  endfunction

  task automatic write_reg(cfg_reg_t idx, logic [31:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    case (idx)
      REG_GAIN_ZERO: gain_m[0] = v[30:0];
      REG_GAIN_ONE: gain_m[1] = v[30:0];
      REG_GAIN_TWO: gain_m[2] = v[30:0];
      REG_BACKGROUND: bg_m = $signed(v);
      REG_REFERENCE: begin
        ref_m = $signed(v);
        kept_m = '{0, 0, 0};
      end
      REG_OWN_INDEX: own_m = v[1:0];
      REG_PENALTY: rho_m = v[30:0];
      REG_SLACK: slack_m = v[30:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_item(logic signed [31:0] f [6], bit typed, duty_res_t res);
    duty_res_t r;
    in_ch.valid <= 1'b1;
    in_ch.dual_zero <= f[0];
    in_ch.dual_one <= f[1];
    in_ch.dual_two <= f[2];
    in_ch.mean_zero <= f[3];
    in_ch.mean_one <= f[4];
    in_ch.mean_two <= f[5];
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    r = predict_duty(f);
    if (typed) duty_q.push_back(res);
    else duty_q.push_back(r);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (duty_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  function automatic logic [31:0] cfg_value(int mode, int which);
    logic [31:0] hi;
    hi = (which == 3 || which == 4) ? 32'hFFFFFFFF : 32'h7FFFFFFF;
    if (mode == 1) return $urandom();
    if (mode == 2) return $urandom_range(0, 1) ? hi : 32'h0;
    if (mode == 3) return $urandom_range(0, 1) ? 32'h80000000 : 32'h7FFFFFFF;
    case (which)
      0, 1, 2: return $urandom_range(0, 3 << 16);
      3: return $urandom_range(0, 50 << 16);
      4: return $urandom_range(0, 200 << 16);
      6: return $urandom_range(6554, 5 << 16);
      7: return $urandom_range(0, 1000);
      default: return 0;
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst_n || quiet) begin
      out_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 12);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    duty_res_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_out++;
      if (duty_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result item at cycle %0d", cycles);
      end else begin
        e = duty_q.pop_front();
        case_hits[e.pick]++;
        if (out_ch.duty_zero !== e.duty[0] || out_ch.duty_one !== e.duty[1] ||
            out_ch.duty_two !== e.duty[2] || out_ch.chosen_case !== e.pick) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp %h %h %h case %0d, got %h %h %h case %0d",
                     e.duty[0], e.duty[1], e.duty[2], e.pick, out_ch.duty_zero,
                     out_ch.duty_one, out_ch.duty_two, out_ch.chosen_case);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > TIMEOUT) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    stim_row_t rows [$];
    stim_row_t row;
    logic signed [31:0] f [6];
    duty_res_t none;
    int mode;
    int total;
    none.duty = '{0, 0, 0};
    none.pick = CASE_UNC;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= REG_GAIN_ZERO;
    cfg_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.dual_zero <= '0;
    in_ch.dual_one <= '0;
    in_ch.dual_two <= '0;
    in_ch.mean_zero <= '0;
    in_ch.mean_one <= '0;
    in_ch.mean_two <= '0;
    gain_m = '{65536, 65536, 65536};
    bg_m = 0;
    ref_m = 0;
    own_m = 0;
    rho_m = 45875;
    slack_m = 66;
    kept_m = '{0, 0, 0};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    row.typed = 1;
    row.res = none;
    row.f = '{-32'sd65536, 0, 0, 0, 0, 0};
    rows.push_back(row);
    row.typed = 0;
    row.f = '{0, 0, 0, 0, 0, 0};
    rows.push_back(row);
    row.f = '{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
              32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF};
    rows.push_back(row);
    row.f = '{32'sh80000000, 32'sh80000000, 32'sh80000000,
              32'sh80000000, 32'sh80000000, 32'sh80000000};
    rows.push_back(row);
    row.f = '{32'sh7FFFFFFF, 32'sh80000000, 0, 32'sh80000000, 32'sh7FFFFFFF, -1};
    rows.push_back(row);
    row.f = '{0, 0, 0, 100 << 16, 100 << 16, 100 << 16};
    rows.push_back(row);
    row.f = '{0, 0, 0, 200 << 16, 50 << 16, 50 << 16};
    rows.push_back(row);
    row.f = '{0, 0, 0, -(10 << 16), 10 << 16, 10 << 16};
    rows.push_back(row);
    row.f = '{1 << 16, -(1 << 16), 2 << 16, 30 << 16, 40 << 16, 50 << 16};
    rows.push_back(row);
    row.f = '{-1, -1, -1, -1, -1, -1};
    rows.push_back(row);
    foreach (rows[k]) send_item(rows[k].f, rows[k].typed, rows[k].res);
    drain_results();

    write_reg(REG_REFERENCE, 150 << 16);
    cfg_we <= 1'b0;
    @(posedge clk);
    foreach (rows[k]) send_item(rows[k].f, 0, none);
    drain_results();

    total = 0;
    for (int p = 0; p < PHASES; p++) begin
      mode = (p < 6) ? 0 : (p % 4);
      for (int r = 0; r < 8; r++) write_reg(cfg_reg_t'(r), cfg_value(mode, r));
      write_reg(REG_OWN_INDEX, p % 4);
      if (p == PHASES - 2) write_reg(REG_PENALTY, 1);
      if (p == PHASES - 1) write_reg(REG_GAIN_ZERO, 0);
      if (p == PHASES - 1) write_reg(REG_GAIN_ONE, 0);
      if (p == PHASES - 1) write_reg(REG_GAIN_TWO, 0);
      cfg_we <= 1'b0;
      @(posedge clk);
      for (int k = 0; k < PER_PHASE; k++) begin
        total++;
        if (p == PHASES - 1 && k > PER_PHASE / 2) quiet = 1;
        for (int i = 0; i < 6; i++) begin
          if ($urandom_range(0, 3) == 0) f[i] = $urandom();
          else if (i < 3) f[i] = $signed($urandom_range(0, 8 << 16)) - (4 << 16);
          else f[i] = $signed($urandom_range(0, 130 << 16)) - (15 << 16);
        end
        send_item(f, 0, none);
      end
      drain_results();
    end

    $display("%0d result items checked over %0d register settings", n_out, PHASES + 2);
    $display("cases 0..6 seen: %0d %0d %0d %0d %0d %0d %0d",
             case_hits[0], case_hits[1], case_hits[2], case_hits[3],
             case_hits[4], case_hits[5], case_hits[6]);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", errors);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
